>>> design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types and constants of the streaming sha-1 hasher
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_word_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       start;
    logic       init;
  } eng_cmd_t;

  localparam int unsigned NUM_WORDS   = 5;
  localparam int unsigned NUM_ROUNDS  = 80;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [5:0]  LEN_OFFSET  = 6'd56;
  localparam logic [5:0]  FILL_LAST   = 6'd63;

  localparam logic [31:0] IV [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

>>> design/sha1_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top
// streaming sha-1: one message byte per word in, five digest words out
//
//   channel  dir  handshake             payload
//   msg      in   msg_valid/msg_stall   data_byte, byte_present, last_byte
//   dig      out  dig_valid/dig_stall   digest_word, word_index, last_word
//
// the 64th byte of a block starts the shared round unit, which runs 80 rounds
// plus one chain update with msg stalled. a last word then pushes one padding
// byte per cycle (9 to 72 bytes, with a pause in the zero state before the
// length bytes) and waits for each compression this triggers, one or two,
// then sends five digest words.
// reset is synchronous; dig holds its word while dig_stall is high.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  output logic                 msg_stall,
  input  sha1_pkg::msg_word_t  msg,
  output logic                 dig_valid,
  input  logic                 dig_stall,
  output sha1_pkg::dig_word_t  dig
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state, state_next;
  logic [2:0]  ret_state, ret_state_next;
  logic [5:0]  fill, fill_next;
  logic [63:0] len, len_next;
  logic [2:0]  len_idx, len_idx_next;
  logic [2:0]  out_idx, out_idx_next;
  logic [63:0] len_sh;
  eng_cmd_t    cmd;
  logic        busy;
  logic [31:0] chain_word;

  assign len_sh = len << {len_idx, 3'b000};

  sha1_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .word_sel   (out_idx),
    .busy       (busy),
    .chain_word (chain_word)
  );

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    fill_next      = fill;
    len_next       = len;
    len_idx_next   = len_idx;
    out_idx_next   = out_idx;
    cmd            = '0;
    msg_stall      = 1'b1;
    dig_valid      = 1'b0;

    unique case (state)
      S_IDLE: begin
        msg_stall = 1'b0;
        if (msg_valid) begin
          if (msg.byte_present) begin
            cmd.push      = 1'b1;
            cmd.push_byte = msg.data_byte;
            fill_next     = fill + 6'd1;
            len_next      = len + 64'd8;
          end
          if (msg.byte_present && fill == FILL_LAST) begin
            cmd.start      = 1'b1;
            ret_state_next = msg.last_byte ? S_PAD80 : S_IDLE;
            state_next     = S_ROUND;
          end else if (msg.last_byte) begin
            state_next = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.push      = 1'b1;
        cmd.push_byte = PAD_BYTE;
        fill_next     = fill + 6'd1;
        if (fill == FILL_LAST) begin
          cmd.start      = 1'b1;
          ret_state_next = S_ZERO;
          state_next     = S_ROUND;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (fill == LEN_OFFSET) begin
          state_next = S_LEN;
        end else begin
          cmd.push      = 1'b1;
          cmd.push_byte = 8'h00;
          fill_next     = fill + 6'd1;
          if (fill == FILL_LAST) begin
            cmd.start      = 1'b1;
            ret_state_next = S_ZERO;
            state_next     = S_ROUND;
          end
        end
      end
      S_LEN: begin
        // length goes out most significant byte first
        cmd.push      = 1'b1;
        cmd.push_byte = len_sh[63:56];
        fill_next     = fill + 6'd1;
        len_idx_next  = len_idx + 3'd1;
        if (len_idx == 3'd7) begin
          cmd.start      = 1'b1;
          ret_state_next = S_OUT;
          state_next     = S_ROUND;
        end
      end
      S_ROUND: begin
        if (!busy) begin
          state_next = ret_state;
        end
      end
      S_OUT: begin
        dig_valid = 1'b1;
        if (!dig_stall) begin
          out_idx_next = out_idx + 3'd1;
          if (out_idx == 3'(NUM_WORDS - 1)) begin
            cmd.init     = 1'b1;
            fill_next    = '0;
            len_next     = '0;
            len_idx_next = '0;
            out_idx_next = '0;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    dig.digest_word = chain_word;
    dig.word_index  = out_idx;
    dig.last_word   = (out_idx == 3'(NUM_WORDS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      fill      <= '0;
      len       <= '0;
      len_idx   <= '0;
      out_idx   <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      fill      <= fill_next;
      len       <= len_next;
      len_idx   <= len_idx_next;
      out_idx   <= out_idx_next;
    end
  end

endmodule

>>> design/sha1_round.sv
// ----------------------------------------------------------------------------
// sha1_round
// one sha-1 round: boolean function, constant and five-input add
// ----------------------------------------------------------------------------
module sha1_round (
  input  sha1_pkg::work_t  work,
  input  logic [31:0]      w,
  input  logic [6:0]       round,
  output sha1_pkg::work_t  work_next
);
  import sha1_pkg::*;

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (round < 7'd20) begin
      f = (work.b & work.c) | (~work.b & work.d);
      k = K0;
    end else if (round < 7'd40) begin
      f = work.b ^ work.c ^ work.d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (work.b & work.c) | (work.b & work.d) | (work.c & work.d);
      k = K2;
    end else begin
      f = work.b ^ work.c ^ work.d;
      k = K3;
    end
  end

  always_comb begin
    work_next.a = rotl(work.a, 5) + f + work.e + k + w;
    work_next.b = work.a;
    work_next.c = rotl(work.b, 30);
    work_next.d = work.c;
    work_next.e = work.d;
  end

endmodule

>>> design/sha1_engine.sv
// ----------------------------------------------------------------------------
// sha1_engine
// block window, message schedule, chain value and the round sequencer
// ----------------------------------------------------------------------------
module sha1_engine (
  input  logic              clk,
  input  logic              rst,
  input  sha1_pkg::eng_cmd_t cmd,
  input  logic [2:0]        word_sel,
  output logic              busy,
  output logic [31:0]       chain_word
);
  import sha1_pkg::*;

  // 16-word window, oldest word in the top bits
  logic [511:0] win;
  logic [31:0]  chain [NUM_WORDS];
  logic [6:0]   round;
  work_t        work;
  work_t        work_next;
  logic [31:0]  w_new;

  assign w_new = rotl(win[511-13*32 -: 32] ^ win[511-8*32 -: 32]
                    ^ win[511-2*32 -: 32] ^ win[511 -: 32], 1);

  sha1_round u_round (
    .work      (work),
    .w         (win[511 -: 32]),
    .round     (round),
    .work_next (work_next)
  );

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win <= {win[503:0], cmd.push_byte};
    end else if (busy && round != 7'(NUM_ROUNDS)) begin
      win <= {win[479:0], w_new};
    end
    if (cmd.start) begin
      work <= '{a: chain[0], b: chain[1], c: chain[2], d: chain[3], e: chain[4]};
    end else if (busy && round != 7'(NUM_ROUNDS)) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= '0;
      for (int i = 0; i < NUM_WORDS; i++) chain[i] <= IV[i];
    end else if (cmd.init) begin
      for (int i = 0; i < NUM_WORDS; i++) chain[i] <= IV[i];
    end else if (cmd.start) begin
      busy  <= 1'b1;
      round <= '0;
    end else if (busy) begin
      if (round != 7'(NUM_ROUNDS)) begin
        round <= round + 7'd1;
      end else begin
        // fold the block result into the chain
        chain[0] <= chain[0] + work.a;
        chain[1] <= chain[1] + work.b;
        chain[2] <= chain[2] + work.c;
        chain[3] <= chain[3] + work.d;
        chain[4] <= chain[4] + work.e;
        busy     <= 1'b0;
      end
    end
  end

  assign chain_word = chain[word_sel];

endmodule
